FILE: rtl/ksv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksv_pkg: shared types and constants of the plucked string voice
// field widths, register codes, operation codes and the span/gain bundle
// ----------------------------------------------------------------------------
package ksv_pkg;

  localparam int unsigned OP_W          = 1;
  localparam int unsigned LOAD_INDEX_W  = 10;
  localparam int unsigned LOAD_VALUE_W  = 16;
  localparam int unsigned DRAW_W        = 8;
  localparam int unsigned SAMPLE_OUT_W  = 16;

  localparam int unsigned CFG_INDEX_W   = 3;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned DELAY_LEN_W   = 11;
  localparam int unsigned SPAN_W        = 7;
  localparam int unsigned GAIN_W        = 16;
  localparam int unsigned GAIN_FRAC     = 15;

  localparam logic [DELAY_LEN_W-1:0] DELAY_LEN_RST  = 11'd100;
  localparam logic [SPAN_W-1:0]      KEEP_RST       = 7'd0;
  localparam logic [SPAN_W-1:0]      FLIP_RST       = 7'd0;
  localparam logic [SPAN_W-1:0]      AVERAGE_RST    = 7'd100;
  localparam logic [SPAN_W-1:0]      NEG_AVERAGE_RST = 7'd0;
  localparam logic [GAIN_W-1:0]      GAIN_RST       = 16'd32768;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 1'b0,
    OP_GENERATE = 1'b1
  } op_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DELAY_LENGTH     = 3'd0,
    CFG_KEEP_SPAN        = 3'd1,
    CFG_FLIP_SPAN        = 3'd2,
    CFG_AVERAGE_SPAN     = 3'd3,
    CFG_NEG_AVERAGE_SPAN = 3'd4,
    CFG_LOOP_GAIN        = 3'd5
  } cfg_reg_e;

  // decision spans and loop gain, as seen by the update logic
  typedef struct packed {
    logic [SPAN_W-1:0] keep;
    logic [SPAN_W-1:0] flip;
    logic [SPAN_W-1:0] average;
    logic [SPAN_W-1:0] neg_average;
    logic [GAIN_W-1:0] gain;
  } spans_t;

endpackage
`default_nettype wire

FILE: rtl/ksv_item_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksv_item_if: input item channel
// valid/ready channel carrying one load or generate item
// ----------------------------------------------------------------------------
interface ksv_item_if;
  logic                                    valid;
  logic                                    ready;
  logic [ksv_pkg::OP_W-1:0]                operation;
  logic [ksv_pkg::LOAD_INDEX_W-1:0]        load_index;
  logic signed [ksv_pkg::LOAD_VALUE_W-1:0] load_value;
  logic [ksv_pkg::DRAW_W-1:0]              draw;

  modport source (output valid, operation, load_index, load_value, draw, input ready);
  modport sink   (input valid, operation, load_index, load_value, draw, output ready);
endinterface
`default_nettype wire

FILE: rtl/ksv_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksv_sample_if: output sample channel
// valid/ready channel carrying one Q1.15 output sample
// ----------------------------------------------------------------------------
interface ksv_sample_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ksv_pkg::SAMPLE_OUT_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/ksv_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksv_ram: generic simple dual-port ram
// one write port, one read port with registered read data (old data on hit)
// ----------------------------------------------------------------------------
module ksv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/ksv_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksv_update: string loop update of one delay line entry
// span decision on the draw, then keep, negate, or (negated) gain * average
// ----------------------------------------------------------------------------
module ksv_update #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic signed [SAMPLE_BITS-1:0]  cur_i,
  input  wire logic signed [SAMPLE_BITS-1:0]  prev_i,
  input  wire logic [ksv_pkg::DRAW_W-1:0]     draw_i,
  input  wire ksv_pkg::spans_t                spans_i,
  output logic signed [SAMPLE_BITS-1:0]       next_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned WW = SB + 18;
  localparam int unsigned CW = ksv_pkg::DRAW_W + 1;
  localparam logic signed [WW-1:0] SMAX = {{(WW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [WW-1:0] SMIN = ~SMAX;
  localparam logic signed [WW-1:0] HALF = WW'(1) <<< (ksv_pkg::GAIN_FRAC - 1);

  logic [CW-1:0]            d, c1, c2, c3, c4;
  logic                     flip, average, negate_avg;
  logic signed [SB:0]       sum;
  logic signed [SB-1:0]     avg;
  logic signed [ksv_pkg::GAIN_W:0] gain_s;
  logic signed [SB+16:0]    prod;
  logic signed [WW-1:0]     sprod, rounded, neg_cur, pick;

  // cumulative span bounds
  always_comb begin
    d  = CW'(draw_i);
    c1 = CW'(spans_i.keep);
    c2 = c1 + CW'(spans_i.flip);
    c3 = c2 + CW'(spans_i.average);
    c4 = c3 + CW'(spans_i.neg_average);
    flip       = (d > c1) && (d <= c2);
    average    = (d > c2) && (d <= c4);
    negate_avg = (d > c3);
  end

  // average truncates, product rounds half up
  always_comb begin
    sum     = (SB+1)'(cur_i) + (SB+1)'(prev_i);
    avg     = sum[SB:1];
    gain_s  = signed'({1'b0, spans_i.gain});
    prod    = (SB+17)'(avg) * (SB+17)'(gain_s);
    sprod   = negate_avg ? -WW'(prod) : WW'(prod);
    rounded = (sprod + HALF) >>> ksv_pkg::GAIN_FRAC;
    neg_cur = -WW'(cur_i);
    if (flip) begin
      pick = neg_cur;
    end else if (average) begin
      pick = rounded;
    end else begin
      pick = WW'(cur_i);
    end
    if (pick > SMAX) begin
      next_o = SMAX[SB-1:0];
    end else if (pick < SMIN) begin
      next_o = SMIN[SB-1:0];
    end else begin
      next_o = pick[SB-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/karplus_strong_voice.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// karplus_strong_voice: extended plucked string / drum voice
// circular delay line of Q1.15 samples with probabilistic per-sample update
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake            payload
//  item_i     in   valid / ready        operation, load_index, load_value, draw
//  sample_o   out  valid / ready        sample_out
//  cfg        in   cfg_we_i (no ready)  cfg_index_i, cfg_data_i
//
//  one item per cycle sustained while the output is not stalled; a generate
//  result passes the item stage (registered ram read), then the output register
//  read address is the running read position, so the ram read is issued at
//  the input transfer; the entry is written back when the item retires
//  a write and a read of the same entry at one edge are forwarded
//  reset clears position, previous sample, handshake state and registers;
//  the delay line is not cleared, no start-up pass
//  a stalled output holds the item stage; a load item retires regardless
//
module karplus_strong_voice #(
  parameter int unsigned DELAY_DEPTH = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  ksv_item_if.sink                                item_i,
  ksv_sample_if.source                            sample_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [ksv_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire logic [ksv_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned AW    = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int unsigned IW    = ksv_pkg::LOAD_INDEX_W;
  localparam int unsigned LW    = ksv_pkg::DELAY_LEN_W;
  // position compare width, wide enough for the length and for depth itself
  localparam int unsigned CW    = (AW + 1 > LW) ? AW + 1 : LW;
  // load index modulo depth via reciprocal multiply plus one correction
  localparam int unsigned RSH   = 20;
  localparam int unsigned RECIP = (32'd1 << RSH) / DELAY_DEPTH;
  localparam int unsigned QDW   = IW + AW + 1;
  localparam int unsigned WW    = SB + 18;
  localparam logic signed [WW-1:0] SMAX = {{(WW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [WW-1:0] SMIN = ~SMAX;

  // configuration registers
  logic [LW-1:0]    delay_len_q;
  ksv_pkg::spans_t  spans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_len_q         <= ksv_pkg::DELAY_LEN_RST;
      spans_q.keep        <= ksv_pkg::KEEP_RST;
      spans_q.flip        <= ksv_pkg::FLIP_RST;
      spans_q.average     <= ksv_pkg::AVERAGE_RST;
      spans_q.neg_average <= ksv_pkg::NEG_AVERAGE_RST;
      spans_q.gain        <= ksv_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      case (ksv_pkg::cfg_reg_e'(cfg_index_i))
        ksv_pkg::CFG_DELAY_LENGTH:     delay_len_q <= cfg_data_i[LW-1:0];
        ksv_pkg::CFG_KEEP_SPAN:        spans_q.keep <= cfg_data_i[ksv_pkg::SPAN_W-1:0];
        ksv_pkg::CFG_FLIP_SPAN:        spans_q.flip <= cfg_data_i[ksv_pkg::SPAN_W-1:0];
        ksv_pkg::CFG_AVERAGE_SPAN:     spans_q.average <= cfg_data_i[ksv_pkg::SPAN_W-1:0];
        ksv_pkg::CFG_NEG_AVERAGE_SPAN: spans_q.neg_average <= cfg_data_i[ksv_pkg::SPAN_W-1:0];
        ksv_pkg::CFG_LOOP_GAIN:        spans_q.gain <= cfg_data_i[ksv_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and stage control
  logic in_xfer, out_free, s1_adv, s1_is_load;
  logic s1_valid_q;
  logic [ksv_pkg::OP_W-1:0] s1_op_q;

  assign out_free   = !sample_o.valid || sample_o.ready;
  assign s1_is_load = (s1_op_q == ksv_pkg::OP_LOAD);
  // a load needs no output slot, a generate waits for one
  assign s1_adv     = s1_valid_q && (s1_is_load || out_free);
  assign item_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer    = item_i.valid && item_i.ready;

  // read position, advanced at input transfer and restarted by a load
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] pos_inc, len_eff;

  always_comb begin
    if (delay_len_q == '0) begin
      len_eff = CW'(1);
    end else if (CW'(delay_len_q) > CW'(DELAY_DEPTH)) begin
      len_eff = CW'(DELAY_DEPTH);
    end else begin
      len_eff = CW'(delay_len_q);
    end
    pos_inc = CW'(pos_q) + CW'(1);
    pos_d   = pos_q;
    if (in_xfer) begin
      if (item_i.operation == ksv_pkg::OP_LOAD) begin
        pos_d = '0;
      end else if (pos_inc >= len_eff) begin
        pos_d = '0;
      end else begin
        pos_d = pos_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // item stage registers
  logic [IW-1:0]                           s1_idx_q, s1_quot_q;
  logic signed [ksv_pkg::LOAD_VALUE_W-1:0] s1_value_q;
  logic [ksv_pkg::DRAW_W-1:0]              s1_draw_q;
  logic [AW-1:0]                           s1_pos_q;
  logic                                    s1_byp_q;
  logic [SB-1:0]                           s1_byp_data_q;
  logic [IW+RSH-1:0]                       quot_prod;

  // ram write port, driven by the retiring item
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SB-1:0] ram_wdata, ram_rdata;

  assign quot_prod = (IW+RSH)'(item_i.load_index) * (IW+RSH)'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q       <= item_i.operation;
      s1_idx_q      <= item_i.load_index;
      s1_quot_q     <= quot_prod[IW+RSH-1:RSH];
      s1_value_q    <= item_i.load_value;
      s1_draw_q     <= item_i.draw;
      s1_pos_q      <= pos_q;
      // entry being written back at this very edge: take the new value
      s1_byp_q      <= ram_we && (ram_waddr == pos_q);
      s1_byp_data_q <= ram_wdata;
    end
  end

  ksv_ram #(
    .WIDTH (SB),
    .DEPTH (DELAY_DEPTH)
  ) u_delay_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // load address: index minus quotient * depth, one correction step
  logic [QDW-1:0]  quot_depth;
  logic [IW-1:0]   rem0, rem1;
  logic [AW-1:0]   load_addr;

  always_comb begin
    quot_depth = QDW'(s1_quot_q) * QDW'(DELAY_DEPTH);
    rem0       = s1_idx_q - quot_depth[IW-1:0];
    if (QDW'(rem0) >= QDW'(DELAY_DEPTH)) begin
      rem1 = rem0 - IW'(DELAY_DEPTH);
    end else begin
      rem1 = rem0;
    end
    load_addr = AW'(rem1);
  end

  // load value saturated to the sample width
  logic signed [WW-1:0] ld_ext;
  logic signed [SB-1:0] ld_sat;

  always_comb begin
    ld_ext = WW'(s1_value_q);
    if (ld_ext > SMAX) begin
      ld_sat = SMAX[SB-1:0];
    end else if (ld_ext < SMIN) begin
      ld_sat = SMIN[SB-1:0];
    end else begin
      ld_sat = ld_ext[SB-1:0];
    end
  end

  // generate path
  logic signed [SB-1:0] prev_q, cur, next_sample;

  assign cur = s1_byp_q ? s1_byp_data_q : ram_rdata;

  ksv_update #(
    .SAMPLE_BITS (SB)
  ) u_update (
    .cur_i   (cur),
    .prev_i  (prev_q),
    .draw_i  (s1_draw_q),
    .spans_i (spans_q),
    .next_o  (next_sample)
  );

  assign ram_we    = s1_adv;
  assign ram_waddr = s1_is_load ? load_addr : s1_pos_q;
  assign ram_wdata = s1_is_load ? ld_sat : next_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (s1_adv) begin
      prev_q <= s1_is_load ? '0 : next_sample;
    end
  end

  // output register
  logic                                    out_valid_q;
  logic signed [ksv_pkg::SAMPLE_OUT_W-1:0] out_data_q;
  logic signed [WW-1:0]                    next_ext;

  assign next_ext = WW'(next_sample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && !s1_is_load) begin
      out_valid_q <= 1'b1;
    end else if (sample_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1_is_load) begin
      out_data_q <= next_ext[ksv_pkg::SAMPLE_OUT_W-1:0];
    end
  end

  assign sample_o.valid      = out_valid_q;
  assign sample_o.sample_out = out_data_q;

  // checks
  a_load_restarts_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && item_i.operation == ksv_pkg::OP_LOAD) |=> (pos_q == '0))
    else $error("read position not restarted by load");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(pos_q) < CW'(DELAY_DEPTH))
    else $error("read position beyond delay depth");

  a_load_clears_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_is_load) |=> (prev_q == '0))
    else $error("previous sample not cleared by load");

  a_forward_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && ram_we && ram_waddr == pos_q) |=> s1_byp_q)
    else $error("same-edge write not forwarded");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> (s1_valid_q && !s1_is_load && out_valid_q && !sample_o.ready))
    else $error("input stalled without a blocked output");

endmodule
`default_nettype wire
